[rtl/dali_pkg.sv]
// Shared types and constants for the DALI forward/backward frame transceiver.
// No dependencies; every other file of the block imports this package.
package dali_pkg;

	// item function codes
	typedef enum logic [1:0] {
		FUNC_TICK     = 2'd0,
		FUNC_SEND     = 2'd1,
		FUNC_RX_START = 2'd2
	} func_t;

	// frame and address constants
	localparam logic [7:0] BCAST_ADDR = 8'hFF;
	localparam logic [7:0] DEMO_CMD   = 8'hFF;
	localparam logic [7:0] SCENE_CMD  = 8'h10;
	localparam logic [7:0] INIT_ADDR  = 8'hA5;
	localparam logic [7:0] RAND_ADDR  = 8'hA7;
	localparam logic [7:0] GROUP_MASK = 8'hE0;
	localparam logic [7:0] SPECIAL_A  = 8'hA0;
	localparam logic [7:0] SPECIAL_C  = 8'hC0;
	localparam logic [7:0] REP_LO     = 8'h20;
	localparam logic [7:0] REP_HI     = 8'h80;

	// forward frame slot numbers (four slots per half bit)
	localparam logic [7:0] FIRST_BIT_SLOT = 8'd4;
	localparam logic [7:0] CMD_SLOT       = 8'd68;
	localparam logic [7:0] LAST_BIT_SLOT  = 8'd128;
	localparam logic [7:0] STOP_SLOT      = 8'd132;
	localparam logic [7:0] END_SLOT       = 8'd236;

	// backward frame timing in ticks
	localparam logic [7:0] RX_MIN_EDGE = 8'd6;
	localparam logic [7:0] RX_HALF_TO  = 8'd8;
	localparam logic [7:0] RX_BIT_TO   = 8'd10;
	localparam logic [3:0] RX_STOP1    = 4'd9;
	localparam logic [3:0] RX_STOP2    = 4'd10;

	localparam logic [15:0] DEMO_PERIOD_RESET = 16'd28800;

	// receiver status after an update
	typedef struct packed {
		logic       on;
		logic [7:0] answer;
		logic       ready;
	} rx_status_t;

	// transmitter / frame status after an update
	typedef struct packed {
		logic       drive;
		logic       on;
		logic       accepted;
		logic       resend;
		logic       fresh;
		logic [7:0] addr;
		logic [7:0] cmd;
	} fwd_status_t;

endpackage

[rtl/dali_rx.sv]
// Backward frame receiver: edge timing, data bit capture and timeouts.
// Depends on dali_pkg.
module dali_rx
	import dali_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  func_t      func,
	input  logic       lvl,
	output logic       rx_on,
	output rx_status_t nxt
);

	logic       on_q, on_d;
	logic [7:0] ticks_q, ticks_d;
	logic       last_q, last_d;
	logic [3:0] idx_q, idx_d;
	logic [7:0] ans_q, ans_d;
	logic       ready_d;
	logic [7:0] t;
	logic [3:0] pos4;

	assign t    = ticks_q + 8'd1;
	assign pos4 = 4'd8 - idx_q;

	// next state for one item
	always_comb begin
		on_d    = on_q;
		ticks_d = ticks_q;
		last_d  = last_q;
		idx_d   = idx_q;
		ans_d   = ans_q;
		ready_d = 1'b0;
		case (func)
			FUNC_TICK: begin
				if (on_q) begin
					ticks_d = t;
					if (lvl != last_q) begin
						if (idx_q == 4'd0) begin
							idx_d   = 4'd1;
							ticks_d = 8'd0;
						end else if (idx_q == RX_STOP1) begin
							if (t > RX_MIN_EDGE) on_d = 1'b0;
						end else if (idx_q == RX_STOP2) begin
							on_d = 1'b0;
						end else if (t > RX_MIN_EDGE) begin
							if (lvl) ans_d = ans_q | (8'd1 << pos4[2:0]);
							idx_d   = idx_q + 4'd1;
							ticks_d = 8'd0;
						end
						last_d = lvl;
					end else begin
						if (idx_q == 4'd0) begin
							if (t == RX_HALF_TO) on_d = 1'b0;
						end else if (idx_q == RX_STOP1) begin
							if (t == RX_HALF_TO) begin
								if (!lvl) begin
									on_d = 1'b0;
								end else begin
									idx_d   = RX_STOP2;
									ticks_d = 8'd0;
								end
							end
						end else if (idx_q == RX_STOP2) begin
							if (t == RX_HALF_TO) begin
								ready_d = 1'b1;
								on_d    = 1'b0;
							end
						end else if (t == RX_BIT_TO) begin
							on_d = 1'b0;
						end
					end
				end
			end
			FUNC_RX_START: begin
				ans_d   = 8'd0;
				idx_d   = 4'd0;
				last_d  = 1'b0;
				ticks_d = 8'd0;
				on_d    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q    <= 1'b0;
			ticks_q <= 8'd0;
			last_q  <= 1'b0;
			idx_q   <= 4'd0;
			ans_q   <= 8'd0;
		end else if (en) begin
			on_q    <= on_d;
			ticks_q <= ticks_d;
			last_q  <= last_d;
			idx_q   <= idx_d;
			ans_q   <= ans_d;
		end
	end

	assign rx_on      = on_q;
	assign nxt.on     = on_d;
	assign nxt.answer = ans_d;
	assign nxt.ready  = ready_d;

endmodule

[rtl/dali_fwd.sv]
// Forward frame transmitter with frame latch, repeat flag and demo scene stepping.
// Depends on dali_pkg.
module dali_fwd
	import dali_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  func_t       func,
	input  logic [7:0]  tx_address,
	input  logic [7:0]  tx_command,
	input  logic        rx_on,
	input  logic [15:0] demo_period,
	output fwd_status_t nxt
);

	logic        on_q, on_d;
	logic [7:0]  slot_q, slot_d;
	logic        nl_q, nl_d;
	logic        drive_q, drive_d;
	logic [7:0]  addr_q, addr_d;
	logic [7:0]  cmd_q, cmd_d;
	logic        rep_q, rep_d;
	logic        demo_q, demo_d;
	logic [15:0] cnt_q, cnt_d;
	logic [3:0]  scene_q, scene_d;
	logic        acc_d, resend_d, fresh_d;
	logic [15:0] cnt_inc;
	logic [3:0]  scene_inc;
	logic [7:0]  slot_off;
	logic        data_bit;

	// bit of the frame sent in the current data slot, MSB first
	assign slot_off = (slot_q < CMD_SLOT) ? (8'd64 - slot_q) : (LAST_BIT_SLOT - slot_q);
	assign data_bit = (slot_q < CMD_SLOT) ? addr_q[slot_off[5:3]] : cmd_q[slot_off[5:3]];

	assign cnt_inc   = cnt_q + 16'd1;
	assign scene_inc = scene_q + 4'd1;

	// next state for one item
	always_comb begin
		on_d     = on_q;
		slot_d   = slot_q;
		nl_d     = nl_q;
		drive_d  = drive_q;
		addr_d   = addr_q;
		cmd_d    = cmd_q;
		rep_d    = rep_q;
		demo_d   = demo_q;
		cnt_d    = cnt_q;
		scene_d  = scene_q;
		acc_d    = 1'b0;
		resend_d = 1'b0;
		fresh_d  = 1'b0;
		case (func)
			FUNC_TICK: begin
				// transmit slot
				if (on_q) begin
					if (slot_q[1:0] == 2'd0) begin
						drive_d = nl_q;
						if (slot_q == 8'd0) nl_d = 1'b1;
						if (slot_q >= FIRST_BIT_SLOT && slot_q <= LAST_BIT_SLOT)
							nl_d = slot_q[2] ? ~data_bit : data_bit;
						if (slot_q == STOP_SLOT) nl_d = 1'b1;
						if (slot_q == END_SLOT) begin
							on_d = 1'b0;
							if (rep_q) resend_d = 1'b1;
						end
					end
					slot_d = slot_q + 8'd1;
				end
				// demo scene stepping
				if (demo_q) begin
					cnt_d = cnt_inc;
					if (cnt_inc == demo_period) begin
						cnt_d    = 16'd0;
						scene_d  = scene_inc;
						addr_d   = BCAST_ADDR;
						cmd_d    = SCENE_CMD + {4'd0, scene_inc};
						fresh_d  = 1'b1;
						resend_d = 1'b1;
					end
				end
			end
			FUNC_SEND: begin
				if (!on_q && !rx_on) begin
					acc_d  = 1'b1;
					addr_d = tx_address;
					cmd_d  = tx_command;
					if (tx_address == BCAST_ADDR && tx_command == DEMO_CMD) begin
						cnt_d   = 16'd0;
						scene_d = 4'd0;
						cmd_d   = SCENE_CMD;
						demo_d  = 1'b1;
						fresh_d = 1'b1;
					end
					// commands that go out twice
					if (rep_q) begin
						rep_d = 1'b0;
					end else if (tx_address[0]) begin
						if ((tx_address & GROUP_MASK) == SPECIAL_A ||
						    (tx_address & GROUP_MASK) == SPECIAL_C) begin
							if (tx_address == INIT_ADDR || tx_address == RAND_ADDR)
								rep_d = 1'b1;
						end else if (cmd_d >= REP_LO && cmd_d <= REP_HI) begin
							rep_d = 1'b1;
						end
					end
					nl_d   = 1'b0;
					slot_d = 8'd0;
					on_d   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q    <= 1'b0;
			slot_q  <= 8'd0;
			nl_q    <= 1'b0;
			drive_q <= 1'b0;
			addr_q  <= 8'd0;
			cmd_q   <= 8'd0;
			rep_q   <= 1'b0;
			demo_q  <= 1'b0;
			cnt_q   <= 16'd0;
			scene_q <= 4'd0;
		end else if (en) begin
			on_q    <= on_d;
			slot_q  <= slot_d;
			nl_q    <= nl_d;
			drive_q <= drive_d;
			addr_q  <= addr_d;
			cmd_q   <= cmd_d;
			rep_q   <= rep_d;
			demo_q  <= demo_d;
			cnt_q   <= cnt_d;
			scene_q <= scene_d;
		end
	end

	assign nxt.drive    = drive_d;
	assign nxt.on       = on_d;
	assign nxt.accepted = acc_d;
	assign nxt.resend   = resend_d;
	assign nxt.fresh    = fresh_d;
	assign nxt.addr     = addr_d;
	assign nxt.cmd      = cmd_d;

endmodule

[rtl/dali_manchester_transceiver_top.sv]
// DALI Manchester forward/backward frame transceiver, top level.
// Input register, result register, demo period register.
// Depends on dali_pkg, dali_rx and dali_fwd.
//
// Usage:
//  - Input channel (in_valid/in_stall): one item per transfer; func selects a
//    tick, a send request (tx_address/tx_command) or a receive start.
//  - Output channel (out_valid/out_stall): exactly one result per item, in
//    order, showing the status after that item.
//  - cfg_we/cfg_wdata write demo_period; write only while the block is idle.
//  - Path: the result of an item is offered from the result register, after it
//    has passed the input register; a stall can hold it in the input register.
//  - Throughput: one item per cycle unless out_stall holds a full result register;
//    the frame and receiver state update in a single pass between the input register and the result register.
//  - Stall: while out_stall holds a full result register, the item in the
//    input register waits and in_stall rises; nothing is lost or repeated.
//  - Reset (arst_n low): frame and receiver state clears, demo_period returns to 28800,
//    both channels empty; the data fields of the two registers are not reset.
module dali_manchester_transceiver_top
	import dali_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic        line_in,
	input  logic [7:0]  tx_address,
	input  logic [7:0]  tx_command,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        line_out,
	output logic        send_accepted,
	output logic        tx_busy,
	output logic        rx_busy,
	output logic [7:0]  answer_byte,
	output logic        answer_ready,
	output logic        resend_request,
	output logic        new_frame,
	output logic [7:0]  frame_address,
	output logic [7:0]  frame_command,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic        valid_s1;
	func_t       func_s1;
	logic        line_s1;
	logic [7:0]  addr_s1;
	logic [7:0]  cmd_s1;
	logic        advance;
	logic        take;
	logic [15:0] demo_period_q;
	logic        rx_on;
	rx_status_t  rx_nxt;
	fwd_status_t fwd_nxt;
	logic        out_valid_q;
	rx_status_t  rx_res_q;
	fwd_status_t fwd_res_q;

	// handshake: the staged item moves on when the result register is free or its result is taken
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			demo_period_q <= DEMO_PERIOD_RESET;
		end else if (cfg_we) begin
			demo_period_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			func_s1 <= func_t'(func);
			line_s1 <= line_in;
			addr_s1 <= tx_address;
			cmd_s1  <= tx_command;
		end
	end

	dali_rx u_rx (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.func   (func_s1),
		.lvl    (line_s1),
		.rx_on  (rx_on),
		.nxt    (rx_nxt)
	);

	dali_fwd u_fwd (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.func        (func_s1),
		.tx_address  (addr_s1),
		.tx_command  (cmd_s1),
		.rx_on       (rx_on),
		.demo_period (demo_period_q),
		.nxt         (fwd_nxt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rx_res_q  <= rx_nxt;
			fwd_res_q <= fwd_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign line_out       = fwd_res_q.drive;
	assign send_accepted  = fwd_res_q.accepted;
	assign tx_busy        = fwd_res_q.on;
	assign rx_busy        = rx_res_q.on;
	assign answer_byte    = rx_res_q.answer;
	assign answer_ready   = rx_res_q.ready;
	assign resend_request = fwd_res_q.resend;
	assign new_frame      = fwd_res_q.fresh;
	assign frame_address  = fwd_res_q.addr;
	assign frame_command  = fwd_res_q.cmd;

	// a taken send request always starts a frame
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fwd_res_q.accepted |-> fwd_res_q.on)
		else $error("send accepted without frame in progress");

	// a completed backward frame ends reception
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rx_res_q.ready |-> !rx_res_q.on)
		else $error("answer ready while receiver still busy");

	// a demo load always targets the broadcast address
	a_demo_bcast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fwd_res_q.fresh |-> fwd_res_q.addr == BCAST_ADDR)
		else $error("demo frame not broadcast");

	// a stalled result that is not taken stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(fwd_res_q) && $stable(rx_res_q))
		else $error("stalled result changed");

endmodule
